### src/gbn_pkg.sv
// Shared types and constants for the go-back-n link controller.
// Holds the event, result and link state records used by the step logic and the top level.
// No dependencies.
package gbn_pkg;

    localparam int SEQ_W       = 7;
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;

    localparam logic [SEQ_W-1:0] MAX_SEQUENCE = 7'd127;

    typedef enum logic [2:0] {
        CMD_PKT_READY = 3'd0,
        CMD_PHY_READY = 3'd1,
        CMD_FRAME_RX  = 3'd2,
        CMD_DATA_TMO  = 3'd3,
        CMD_ACK_TMO   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_SEND_DATA   = 3'd1,
        ACT_SEND_ACK    = 3'd2,
        ACT_DELIVER     = 3'd3,
        ACT_STOP_TIMERS = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ATMR_LEAVE = 2'd0,
        ATMR_START = 2'd1,
        ATMR_STOP  = 2'd2
    } t_ack_tmr;

    typedef struct packed {
        logic [SEQ_W-1:0] next_to_send;
        logic [SEQ_W-1:0] oldest_unacked;
        logic [SEQ_W-1:0] buffered_count;
        logic [SEQ_W-1:0] expected_receive;
        logic             link_ready;
    } t_link_state;

    typedef struct packed {
        logic [2:0]       command;
        logic             frame_good;
        logic             frame_is_data;
        logic [SEQ_W-1:0] frame_seq;
        logic [SEQ_W-1:0] ack_number;
    } t_event;

    typedef struct packed {
        t_action          action;
        logic [SEQ_W-1:0] seq_number;
        logic [SEQ_W-1:0] ack_value;
        logic [SEQ_W-1:0] timer_count;
        t_ack_tmr         ack_timer_cmd;
        logic             network_enable;
        logic             last;
    } t_result;

endpackage

### src/gbn_step.sv
// Combinational event logic of the go-back-n link controller.
// Maps one event and the current link state to the next state and an ordered result list.
// Depends on gbn_pkg.
module gbn_step (
    input  gbn_pkg::t_event      i_evt,
    input  gbn_pkg::t_link_state i_state,
    output gbn_pkg::t_link_state o_state,
    output gbn_pkg::t_result     o_list [gbn_pkg::MAX_RESULTS],
    output logic [gbn_pkg::RES_CNT_W-1:0] o_num
);

    function automatic gbn_pkg::t_result mk_res(
        input gbn_pkg::t_action          action,
        input logic [gbn_pkg::SEQ_W-1:0] seq,
        input logic [gbn_pkg::SEQ_W-1:0] ack,
        input logic [gbn_pkg::SEQ_W-1:0] count,
        input gbn_pkg::t_ack_tmr         atmr
    );
        gbn_pkg::t_result r;
        r.action         = action;
        r.seq_number     = seq;
        r.ack_value      = ack;
        r.timer_count    = count;
        r.ack_timer_cmd  = atmr;
        r.network_enable = 1'b0;
        r.last           = 1'b0;
        return r;
    endfunction

    localparam logic [gbn_pkg::SEQ_W-1:0] SEQ_ONE  = 7'd1;
    localparam logic [gbn_pkg::SEQ_W-1:0] SEQ_ZERO = 7'd0;

    always_comb begin
        gbn_pkg::t_link_state st;
        gbn_pkg::t_result     p0;
        gbn_pkg::t_result     p1;
        gbn_pkg::t_result     ps;
        logic                 v0;
        logic                 v1;
        logic                 vs;
        logic [gbn_pkg::SEQ_W-1:0] ack_dist;
        logic [gbn_pkg::SEQ_W-1:0] k;
        logic [gbn_pkg::SEQ_W-1:0] upper;
        logic [gbn_pkg::SEQ_W-1:0] nts_dist;
        logic [gbn_pkg::RES_CNT_W-1:0] n;
        logic                 en;

        st       = i_state;
        p0       = mk_res(gbn_pkg::ACT_NONE, SEQ_ZERO, SEQ_ZERO, SEQ_ZERO, gbn_pkg::ATMR_LEAVE);
        p1       = p0;
        v0       = 1'b0;
        v1       = 1'b0;
        ack_dist = i_evt.ack_number - st.oldest_unacked;
        k        = ack_dist + SEQ_ONE;
        upper    = '0;
        nts_dist = '0;

        unique case (gbn_pkg::t_cmd'(i_evt.command))
            gbn_pkg::CMD_PKT_READY: begin
                if (st.buffered_count < gbn_pkg::MAX_SEQUENCE) begin
                    st.buffered_count = st.buffered_count + SEQ_ONE;
                    v0 = 1'b1;
                    p0 = mk_res(gbn_pkg::ACT_SEND_DATA, st.next_to_send,
                                st.expected_receive - SEQ_ONE, SEQ_ZERO, gbn_pkg::ATMR_STOP);
                    st.next_to_send = st.next_to_send + SEQ_ONE;
                    st.link_ready   = 1'b0;
                end
            end
            gbn_pkg::CMD_PHY_READY: begin
                st.link_ready = 1'b1;
            end
            gbn_pkg::CMD_FRAME_RX: begin
                if (i_evt.frame_good) begin
                    if (i_evt.frame_is_data) begin
                        v0 = 1'b1;
                        if (i_evt.frame_seq == st.expected_receive) begin
                            p0 = mk_res(gbn_pkg::ACT_DELIVER, i_evt.frame_seq,
                                        st.expected_receive - SEQ_ONE, SEQ_ZERO,
                                        gbn_pkg::ATMR_START);
                            st.expected_receive = st.expected_receive + SEQ_ONE;
                        end else begin
                            p0 = mk_res(gbn_pkg::ACT_NONE, SEQ_ZERO,
                                        st.expected_receive - SEQ_ONE, SEQ_ZERO,
                                        gbn_pkg::ATMR_START);
                        end
                    end
                    if (ack_dist < st.buffered_count) begin
                        v1 = 1'b1;
                        p1 = mk_res(gbn_pkg::ACT_STOP_TIMERS, st.oldest_unacked,
                                    st.expected_receive - SEQ_ONE, k, gbn_pkg::ATMR_LEAVE);
                        st.oldest_unacked = i_evt.ack_number + SEQ_ONE;
                        st.buffered_count = st.buffered_count - k;
                        upper    = st.oldest_unacked + st.buffered_count;
                        nts_dist = st.next_to_send - st.oldest_unacked;
                        if (st.next_to_send != upper && nts_dist >= st.buffered_count) begin
                            st.next_to_send = st.oldest_unacked;
                        end
                    end
                end
            end
            gbn_pkg::CMD_DATA_TMO: begin
                st.next_to_send = st.oldest_unacked;
                if (st.buffered_count != SEQ_ZERO) begin
                    v0 = 1'b1;
                    p0 = mk_res(gbn_pkg::ACT_STOP_TIMERS, st.oldest_unacked,
                                st.expected_receive - SEQ_ONE, st.buffered_count,
                                gbn_pkg::ATMR_LEAVE);
                end
            end
            gbn_pkg::CMD_ACK_TMO: begin
                v0 = 1'b1;
                p0 = mk_res(gbn_pkg::ACT_SEND_ACK, SEQ_ZERO, st.expected_receive - SEQ_ONE,
                            SEQ_ZERO, gbn_pkg::ATMR_STOP);
                st.link_ready = 1'b0;
            end
            default: begin
            end
        endcase

        vs = st.link_ready &&
             (st.next_to_send != st.oldest_unacked + st.buffered_count);
        ps = mk_res(gbn_pkg::ACT_SEND_DATA, st.next_to_send, st.expected_receive - SEQ_ONE,
                    SEQ_ZERO, gbn_pkg::ATMR_STOP);
        if (vs) begin
            st.next_to_send = st.next_to_send + SEQ_ONE;
            st.link_ready   = 1'b0;
        end

        en = (st.buffered_count < gbn_pkg::MAX_SEQUENCE) && st.link_ready;

        for (int i = 0; i < gbn_pkg::MAX_RESULTS; i++) begin
            o_list[i] = mk_res(gbn_pkg::ACT_NONE, SEQ_ZERO, st.expected_receive - SEQ_ONE,
                               SEQ_ZERO, gbn_pkg::ATMR_LEAVE);
        end
        n = '0;
        if (v0) begin
            o_list[n] = p0;
            n = n + 2'd1;
        end
        if (v1) begin
            o_list[n] = p1;
            n = n + 2'd1;
        end
        if (vs) begin
            o_list[n] = ps;
            n = n + 2'd1;
        end
        if (n == 2'd0) begin
            n = 2'd1;
        end
        for (int i = 0; i < gbn_pkg::MAX_RESULTS; i++) begin
            o_list[i].network_enable = en;
        end
        o_list[n - 2'd1].last = 1'b1;

        o_state = st;
        o_num   = n;
    end

endmodule

### src/go_back_n_link_controller.sv
// Top level of the go-back-n link controller: input beat register, state, result queue.
// Depends on gbn_pkg and gbn_step.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one link event per beat: packet ready,
//   physical ready, frame received with its check result and numbers, data timeout
//   or ack timeout.
//   Output channel (o_valid / i_stall) returns one to three result beats per event,
//   in order, with o_last on the final beat of each event.
//   An event is held in the input register, then loaded into the result queue,
//   whose head drives the outputs. Throughput: one result beat per cycle while
//   i_stall is low. The three-entry result queue reloads in the cycle its last
//   entry drains.
//   The input register takes the next event while results of the previous one drain.
//   Reset clears all sequence numbers, the buffered count and the link-ready flag
//   and empties both the input register and the result queue.
//   While i_stall is high the shown result holds; once the input register is full
//   and the queue cannot reload, o_stall rises.
module go_back_n_link_controller (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [2:0]                i_command,
    input  logic                      i_frame_good,
    input  logic                      i_frame_is_data,
    input  logic [gbn_pkg::SEQ_W-1:0] i_frame_seq,
    input  logic [gbn_pkg::SEQ_W-1:0] i_ack_number,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_action,
    output logic [gbn_pkg::SEQ_W-1:0] o_seq_number,
    output logic [gbn_pkg::SEQ_W-1:0] o_ack_value,
    output logic [gbn_pkg::SEQ_W-1:0] o_timer_count,
    output logic [1:0]                o_ack_timer_cmd,
    output logic                      o_network_enable,
    output logic                      o_last
);

    logic                          r_in_valid;
    gbn_pkg::t_event               r_evt;
    gbn_pkg::t_link_state          r_state;
    gbn_pkg::t_link_state          n_state;
    gbn_pkg::t_result              r_buf [gbn_pkg::MAX_RESULTS];
    gbn_pkg::t_result              n_list [gbn_pkg::MAX_RESULTS];
    logic [gbn_pkg::RES_CNT_W-1:0] r_cnt;
    logic [gbn_pkg::RES_CNT_W-1:0] n_num;
    logic                          pop;
    logic                          load;
    logic                          in_accept;

    gbn_step u_step (
        .i_evt   (r_evt),
        .i_state (r_state),
        .o_state (n_state),
        .o_list  (n_list),
        .o_num   (n_num)
    );

    assign pop       = o_valid && !i_stall;
    assign load      = r_in_valid && ((r_cnt == 2'd0) || (r_cnt == 2'd1 && pop));
    assign o_stall   = r_in_valid && !load;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_cnt      <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_state <= n_state;
                r_cnt   <= n_num;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_evt.command       <= i_command;
            r_evt.frame_good    <= i_frame_good;
            r_evt.frame_is_data <= i_frame_is_data;
            r_evt.frame_seq     <= i_frame_seq;
            r_evt.ack_number    <= i_ack_number;
        end
        if (load) begin
            r_buf <= n_list;
        end else if (pop) begin
            r_buf[0] <= r_buf[1];
            r_buf[1] <= r_buf[2];
        end
    end

    assign o_valid          = (r_cnt != 2'd0);
    assign o_action         = r_buf[0].action;
    assign o_seq_number     = r_buf[0].seq_number;
    assign o_ack_value      = r_buf[0].ack_value;
    assign o_timer_count    = r_buf[0].timer_count;
    assign o_ack_timer_cmd  = r_buf[0].ack_timer_cmd;
    assign o_network_enable = r_buf[0].network_enable;
    assign o_last           = r_buf[0].last;

endmodule

### src/gbn_checker.sv
// Port-level checks for the go-back-n link controller, bound to the top level.
// Depends on gbn_pkg and go_back_n_link_controller.
module gbn_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [2:0]                o_action,
    input logic [gbn_pkg::SEQ_W-1:0] o_seq_number,
    input logic [gbn_pkg::SEQ_W-1:0] o_timer_count,
    input logic [1:0]                o_ack_timer_cmd,
    input logic                      o_last
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_action) && $stable(o_seq_number)
            && $stable(o_last))
        else $error("stalled result beat changed");

    a_event_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last |=> o_valid)
        else $error("gap inside one event's results");

    a_send_stops_ack_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_action == gbn_pkg::ACT_SEND_DATA || o_action == gbn_pkg::ACT_SEND_ACK)
            |-> o_ack_timer_cmd == gbn_pkg::ATMR_STOP)
        else $error("frame sent without stopping ack timer");

    a_timer_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_action == gbn_pkg::ACT_STOP_TIMERS) == (o_timer_count != 7'd0)))
        else $error("timer count does not match action");

endmodule

bind go_back_n_link_controller gbn_checker u_gbn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_action        (o_action),
    .o_seq_number    (o_seq_number),
    .o_timer_count   (o_timer_count),
    .o_ack_timer_cmd (o_ack_timer_cmd),
    .o_last          (o_last)
);

### tb/sv/tb_go_back_n_link_controller.sv
// Self-checking testbench for go_back_n_link_controller: directed event table,
// then random link traffic checked against an in-bench model of the window state.
// Depends on gbn_pkg and go_back_n_link_controller.
module tb_go_back_n_link_controller;
    import gbn_pkg::*;

    localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
    localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
    localparam int         DIR_ROWS     = 25;
    localparam int         RAND_EVENTS  = 520;
    localparam int         FILL_EVENTS  = 200;

    typedef enum {MIX_FILL, MIX_TRAFFIC, MIX_NOISE} t_mix;

    typedef struct {
        t_event  ev;
        bit      typed;
        t_result want;
    } t_dir_row;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [2:0]       i_command;
    logic             i_frame_good;
    logic             i_frame_is_data;
    logic [SEQ_W-1:0] i_frame_seq;
    logic [SEQ_W-1:0] i_ack_number;
    logic             o_valid;
    logic             i_stall;
    logic [2:0]       o_action;
    logic [SEQ_W-1:0] o_seq_number;
    logic [SEQ_W-1:0] o_ack_value;
    logic [SEQ_W-1:0] o_timer_count;
    logic [1:0]       o_ack_timer_cmd;
    logic             o_network_enable;
    logic             o_last;

    t_link_state link_st;
    t_result     event_results[$];
    t_result     pending_results[$];
    int          quiet_tx;
    int          events_sent;
    int          beats_seen;
    int          refused_full;
    int          acks_retired;
    int          errors;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{CMD_ACK_TMO,   1'b0, 1'b0, 7'd0,   7'd0},   1'b1,
          '{ACT_SEND_ACK,  7'd0, 7'd127, 7'd0, ATMR_STOP,  1'b0, 1'b1}},
        '{'{CMD_UNUSED_7,  1'b1, 1'b1, 7'd127, 7'd127}, 1'b1,
          '{ACT_NONE,      7'd0, 7'd127, 7'd0, ATMR_LEAVE, 1'b0, 1'b1}},
        '{'{CMD_PHY_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b1,
          '{ACT_NONE,      7'd0, 7'd127, 7'd0, ATMR_LEAVE, 1'b1, 1'b1}},
        '{'{CMD_PKT_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b1,
          '{ACT_SEND_DATA, 7'd0, 7'd127, 7'd0, ATMR_STOP,  1'b0, 1'b1}},
        '{'{CMD_PKT_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_DATA_TMO,  1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_PHY_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_FRAME_RX,  1'b0, 1'b1, 7'd0,   7'd0},   1'b1,
          '{ACT_NONE,      7'd0, 7'd127, 7'd0, ATMR_LEAVE, 1'b0, 1'b1}},
        '{'{CMD_FRAME_RX,  1'b1, 1'b1, 7'd0,   7'd127}, 1'b0, '0},
        '{'{CMD_FRAME_RX,  1'b1, 1'b1, 7'd5,   7'd0},   1'b0, '0},
        '{'{CMD_PHY_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_FRAME_RX,  1'b1, 1'b0, 7'd0,   7'd1},   1'b0, '0},
        '{'{CMD_DATA_TMO,  1'b0, 1'b0, 7'd0,   7'd0},   1'b1,
          '{ACT_NONE,      7'd0, 7'd0,   7'd0, ATMR_LEAVE, 1'b0, 1'b1}},
        '{'{CMD_PKT_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_PKT_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_PKT_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_DATA_TMO,  1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_PHY_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_FRAME_RX,  1'b1, 1'b0, 7'd0,   7'd3},   1'b0, '0},
        '{'{CMD_PHY_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_PHY_READY, 1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_DATA_TMO,  1'b0, 1'b0, 7'd0,   7'd0},   1'b0, '0},
        '{'{CMD_UNUSED_5,  1'b1, 1'b0, 7'd0,   7'd127}, 1'b0, '0},
        '{'{CMD_FRAME_RX,  1'b1, 1'b1, 7'd127, 7'd127}, 1'b0, '0},
        '{'{CMD_FRAME_RX,  1'b1, 1'b0, 7'd0,   7'd0},   1'b0, '0}
    };

    go_back_n_link_controller dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_frame_good     (i_frame_good),
        .i_frame_is_data  (i_frame_is_data),
        .i_frame_seq      (i_frame_seq),
        .i_ack_number     (i_ack_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_action         (o_action),
        .o_seq_number     (o_seq_number),
        .o_ack_value      (o_ack_value),
        .o_timer_count    (o_timer_count),
        .o_ack_timer_cmd  (o_ack_timer_cmd),
        .o_network_enable (o_network_enable),
        .o_last           (o_last)
    );

    function automatic void push_result(input t_action act, input logic [SEQ_W-1:0] seq,
                                        input logic [SEQ_W-1:0] cnt, input t_ack_tmr tmr);
        t_result r;
        if (event_results.size() < MAX_RESULTS) begin
            r                = '0;
            r.action         = act;
            r.seq_number     = seq;
            r.ack_value      = link_st.expected_receive + MAX_SEQUENCE;
            r.timer_count    = cnt;
            r.ack_timer_cmd  = tmr;
            event_results.push_back(r);
        end
    endfunction

    function automatic void send_next_frame();
        push_result(ACT_SEND_DATA, link_st.next_to_send, 7'd0, ATMR_STOP);
        link_st.next_to_send = link_st.next_to_send + 7'd1;
        link_st.link_ready   = 1'b0;
    endfunction

    function automatic void advance_link(input t_event ev);
        logic [SEQ_W-1:0] ack_dist;
        logic [SEQ_W-1:0] upper;
        logic [SEQ_W-1:0] behind;
        logic             en;
        event_results.delete();
        case (ev.command)
            CMD_PKT_READY: begin
                if (link_st.buffered_count < MAX_SEQUENCE) begin
                    link_st.buffered_count = link_st.buffered_count + 7'd1;
                    send_next_frame();
                end else begin
                    refused_full++;
                end
            end
            CMD_PHY_READY: begin
                link_st.link_ready = 1'b1;
            end
            CMD_FRAME_RX: begin
                if (ev.frame_good) begin
                    if (ev.frame_is_data) begin
                        if (ev.frame_seq == link_st.expected_receive) begin
                            push_result(ACT_DELIVER, ev.frame_seq, 7'd0, ATMR_START);
                            link_st.expected_receive = link_st.expected_receive + 7'd1;
                        end else begin
                            push_result(ACT_NONE, 7'd0, 7'd0, ATMR_START);
                        end
                    end
                    ack_dist = ev.ack_number - link_st.oldest_unacked;
                    if (ack_dist < link_st.buffered_count) begin
                        acks_retired++;
                        push_result(ACT_STOP_TIMERS, link_st.oldest_unacked, ack_dist + 7'd1,
                                    ATMR_LEAVE);
                        link_st.oldest_unacked = ev.ack_number + 7'd1;
                        link_st.buffered_count = link_st.buffered_count - (ack_dist + 7'd1);
                        upper  = link_st.oldest_unacked + link_st.buffered_count;
                        behind = link_st.next_to_send - link_st.oldest_unacked;
                        if (link_st.next_to_send != upper && behind >= link_st.buffered_count)
                            link_st.next_to_send = link_st.oldest_unacked;
                    end
                end
            end
            CMD_DATA_TMO: begin
                link_st.next_to_send = link_st.oldest_unacked;
                if (link_st.buffered_count != 7'd0)
                    push_result(ACT_STOP_TIMERS, link_st.oldest_unacked,
                                link_st.buffered_count, ATMR_LEAVE);
            end
            CMD_ACK_TMO: begin
                push_result(ACT_SEND_ACK, 7'd0, 7'd0, ATMR_STOP);
                link_st.link_ready = 1'b0;
            end
            default: begin
            end
        endcase
        upper = link_st.oldest_unacked + link_st.buffered_count;
        if (link_st.link_ready && link_st.next_to_send != upper)
            send_next_frame();
        if (event_results.size() == 0)
            push_result(ACT_NONE, 7'd0, 7'd0, ATMR_LEAVE);
        en = (link_st.buffered_count < MAX_SEQUENCE) && link_st.link_ready;
        foreach (event_results[i]) begin
            event_results[i].network_enable = en;
            event_results[i].last           = (i == event_results.size() - 1);
        end
    endfunction

    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet = $urandom_range(8, 30);
        return $urandom_range(0, 8);
    endfunction

    function automatic t_event make_event(input t_mix mix);
        t_event ev;
        int     pick;
        ev.command       = 3'($urandom);
        ev.frame_good    = 1'($urandom);
        ev.frame_is_data = 1'($urandom);
        ev.frame_seq     = 7'($urandom);
        ev.ack_number    = 7'($urandom);
        if (mix == MIX_NOISE)
            return ev;
        pick = $urandom_range(0, 99);
        if (mix == MIX_FILL) begin
            if (pick < 80) begin
                ev.command = CMD_PKT_READY;
            end else if (pick < 90) begin
                ev.command = CMD_PHY_READY;
            end else if (pick < 95) begin
                ev.command    = CMD_FRAME_RX;
                ev.frame_good = 1'b0;
            end else begin
                ev.command = CMD_ACK_TMO;
            end
            return ev;
        end
        if (pick < 25)
            ev.command = CMD_PKT_READY;
        else if (pick < 50)
            ev.command = CMD_PHY_READY;
        else if (pick < 85)
            ev.command = CMD_FRAME_RX;
        else if (pick < 93)
            ev.command = CMD_DATA_TMO;
        else
            ev.command = CMD_ACK_TMO;
        ev.frame_good = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 70)
            ev.frame_seq = link_st.expected_receive;
        if (link_st.buffered_count != 7'd0 && $urandom_range(0, 99) < 75)
            ev.ack_number = link_st.oldest_unacked
                          + 7'($urandom_range(0, link_st.buffered_count - 1));
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s got %0d want %0d",
                                      beats_seen, name, got, want));
    endtask

    task automatic issue_event(input t_event ev, input bit typed, input t_result want);
        int gap;
        advance_link(ev);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (event_results[i]) pending_results.push_back(event_results[i]);
        events_sent++;
        gap = draw_wait(quiet_tx);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= ev.command;
        i_frame_good    <= ev.frame_good;
        i_frame_is_data <= ev.frame_is_data;
        i_frame_seq     <= ev.frame_seq;
        i_ack_number    <= ev.ack_number;
        do @(posedge i_clk); while (o_stall);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAIL");
        $finish;
    end

    initial begin
        int quiet_rx;
        int hold;
        quiet_rx = 0;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold = draw_wait(quiet_rx);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            beats_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
            end else begin
                want = pending_results.pop_front();
                check_field("action",         8'(o_action),         8'(want.action));
                check_field("seq_number",     8'(o_seq_number),     8'(want.seq_number));
                check_field("ack_value",      8'(o_ack_value),      8'(want.ack_value));
                check_field("timer_count",    8'(o_timer_count),    8'(want.timer_count));
                check_field("ack_timer_cmd",  8'(o_ack_timer_cmd),  8'(want.ack_timer_cmd));
                check_field("network_enable", 8'(o_network_enable), 8'(want.network_enable));
                check_field("last",           8'(o_last),           8'(want.last));
            end
        end
    end

    initial begin
        t_mix mix;
        link_st         = '0;
        quiet_tx        = 0;
        events_sent     = 0;
        beats_seen      = 0;
        refused_full    = 0;
        acks_retired    = 0;
        errors          = 0;
        mix             = MIX_FILL;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_command       <= CMD_PKT_READY;
        i_frame_good    <= 1'b0;
        i_frame_is_data <= 1'b0;
        i_frame_seq     <= '0;
        i_ack_number    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r])
            issue_event(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].want);

        for (int n = 0; n < RAND_EVENTS; n++) begin
            if (n >= FILL_EVENTS && (n - FILL_EVENTS) % 40 == 0) begin
                case ($urandom_range(0, 19))
                    0, 1, 2: mix = MIX_NOISE;
                    3, 4, 5: mix = MIX_FILL;
                    default: mix = MIX_TRAFFIC;
                endcase
            end
            issue_event(make_event(mix), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d events (%0d from the table), %0d result beats checked",
                 events_sent, DIR_ROWS, beats_seen);
        $display("packets refused on a full window: %0d, cumulative acks: %0d",
                 refused_full, acks_retired);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
